// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 CBC engine package
// Register indexes, S-box tables and GF(2^8) helpers shared by the engine.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUNDS_DEF = 10;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_HIGH  = 3'd0,
        REG_KEY_LOW   = 3'd1,
        REG_IV_HIGH   = 3'd2,
        REG_IV_LOW    = 3'd3,
        REG_DIRECTION = 3'd4
    } cfg_reg_t;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inv);
        logic [7:0] b [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [31:0] r;
        for (int k = 0; k < 4; k++) begin
            b[k]  = w[31-8*k -: 8];
            x2[k] = xtime(b[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m2[k] = x2[k];
            m3[k] = x2[k] ^ b[k];
            m9[k] = x8[k] ^ b[k];
            mb[k] = x8[k] ^ x2[k] ^ b[k];
            md[k] = x8[k] ^ x4[k] ^ b[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        for (int i = 0; i < 4; i++) begin
            if (inv) begin
                r[31-8*i -: 8] = me[i] ^ mb[(i+1)%4] ^ md[(i+2)%4] ^ m9[(i+3)%4];
            end else begin
                r[31-8*i -: 8] = m2[i] ^ m3[(i+1)%4] ^ b[(i+2)%4] ^ b[(i+3)%4];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/aes_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/aes128_cbc_block_engine.sv =====
// ----------------------------------------------------------------------------
// AES-128 CBC block engine
// Encrypts or decrypts one 128-bit block per request, chained in CBC mode.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// s_      | in        | tdata = {block_low, block_high}, tuser = first_block
// m_      | out       | tdata = {result_low, result_high}
// cfg_    | in        | cfg_index (register), cfg_data (64-bit value)
//
// Key expansion runs after reset and after each key write: 44 words (the key
// itself and 40 derived), one word per cycle into the round-key RAM, during
// which s_tready is low.
// For a block, the shared round unit does one column per cycle, fed by the single
// RAM read port (one key word a cycle).
// The result sits in an output register; the next request is taken once it
// has been accepted.
module aes128_cbc_block_engine #(
    parameter int ROUNDS = aes_pkg::ROUNDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [127:0]                   s_tdata,   // block_low, block_high
    input  logic                           s_tuser,   // first_block
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [127:0]                   m_tdata,   // result_low, result_high
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [aes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                    cfg_data
);

    localparam int KW  = 4 * (ROUNDS + 1);
    localparam int KAW = $clog2(KW);
    localparam int RW  = $clog2(ROUNDS + 1);

    typedef enum logic [2:0] {
        ST_EXPAND, ST_IDLE, ST_PRIME, ST_RUN, ST_DONE
    } state_t;

    state_t           state_reg;
    logic [63:0]      key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic             dir_reg;
    logic [127:0]     chain_reg;
    logic [127:0]     st_reg;     // cipher state, column 0 in top bits
    logic [127:0]     nx_reg;     // next-round state being built
    logic [127:0]     cin_reg;    // input ciphertext, kept for decrypt chaining
    logic [KAW-1:0]   kidx_reg;   // expansion write index / key word read index
    logic [1:0]       col_reg;
    logic [RW-1:0]    rnd_reg;
    logic [7:0]       rcon_reg;
    logic [31:0]      w_hist_reg [4];
    logic             dir_run_reg;

    // key RAM
    logic             ram_we;
    logic [KAW-1:0]   ram_waddr, ram_raddr;
    logic [31:0]      ram_wdata, ram_rdata;

    aes_ram #(.WIDTH(32), .DEPTH(KW)) u_keys (
        .aclk(aclk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
        .rd_addr(ram_raddr), .rd_data(ram_rdata)
    );

    // expansion word
    logic [31:0] exp_word, t_rot, t_sub;
    always_comb begin
        t_rot = {w_hist_reg[3][23:0], w_hist_reg[3][31:24]};
        for (int k = 0; k < 4; k++) begin
            t_sub[8*k +: 8] = aes_pkg::FWD_SBOX[t_rot[8*k +: 8]];
        end
        if (kidx_reg[1:0] == 2'd0) begin
            exp_word = w_hist_reg[0] ^ t_sub ^ {rcon_reg, 24'h0};
        end else begin
            exp_word = w_hist_reg[0] ^ w_hist_reg[3];
        end
    end

    // shared column unit: sub/shift gather, optional mix, key add
    logic [31:0] col_sub, col_mix, col_out;
    logic [7:0]  src;
    logic        last_rnd;
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            logic [1:0] sc;
            if (dir_run_reg) begin
                sc = col_reg - 2'(r);
            end else begin
                sc = col_reg + 2'(r);
            end
            src = st_reg[127 - 32*sc - 8*r -: 8];
            col_sub[31-8*r -: 8] = dir_run_reg ? aes_pkg::INV_SBOX[src]
                                               : aes_pkg::FWD_SBOX[src];
        end
        last_rnd = (rnd_reg == RW'(ROUNDS));
        if (dir_run_reg) begin
            col_mix = col_sub ^ ram_rdata;
            col_out = last_rnd ? col_mix : aes_pkg::mix_col(col_mix, 1'b1);
        end else begin
            col_mix = last_rnd ? col_sub : aes_pkg::mix_col(col_sub, 1'b0);
            col_out = col_mix ^ ram_rdata;
        end
    end

    // key word read address: encrypt counts up from word 4, decrypt goes round by round down
    logic [KAW-1:0] rd_next;
    logic [1:0]     prev_col;
    always_comb begin
        ram_we    = (state_reg == ST_EXPAND);
        ram_waddr = kidx_reg;
        ram_wdata = (kidx_reg < KAW'(4)) ?
                    ((kidx_reg[1] == 1'b0) ? (kidx_reg[0] ? key_high_reg[31:0]
                                                          : key_high_reg[63:32])
                                           : (kidx_reg[0] ? key_low_reg[31:0]
                                                          : key_low_reg[63:32]))
                    : exp_word;
        ram_raddr = kidx_reg;
    end

    logic accept_in, cfg_key;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ST_DONE);
    assign accept_in = s_tvalid && s_tready;
    assign cfg_key   = cfg_valid && (cfg_index == aes_pkg::REG_KEY_HIGH ||
                                     cfg_index == aes_pkg::REG_KEY_LOW);

    logic [127:0] chain_use, blk_in;
    always_comb begin
        chain_use = s_tuser ? {iv_high_reg, iv_low_reg} : chain_reg;
        blk_in    = {s_tdata[63:0], s_tdata[127:64]};
        prev_col  = col_reg - 2'd1;
        // address leads the column in use by one; decrypt drops back a round key
        if (dir_run_reg && col_reg == 2'd2) begin
            rd_next = kidx_reg - KAW'(7);
        end else begin
            rd_next = kidx_reg + KAW'(1);
        end
    end

    logic [127:0] fin;
    assign fin = {nx_reg[127:32], col_out};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_EXPAND;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            dir_reg      <= 1'b0;
            chain_reg    <= '0;
            kidx_reg     <= '0;
            rcon_reg     <= 8'h01;
            rnd_reg      <= '0;
            col_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    aes_pkg::REG_KEY_HIGH:  key_high_reg <= cfg_data;
                    aes_pkg::REG_KEY_LOW:   key_low_reg  <= cfg_data;
                    aes_pkg::REG_IV_HIGH:   iv_high_reg  <= cfg_data;
                    aes_pkg::REG_IV_LOW:    iv_low_reg   <= cfg_data;
                    aes_pkg::REG_DIRECTION: dir_reg      <= cfg_data[0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_EXPAND: begin
                    w_hist_reg[0] <= w_hist_reg[1];
                    w_hist_reg[1] <= w_hist_reg[2];
                    w_hist_reg[2] <= w_hist_reg[3];
                    w_hist_reg[3] <= ram_wdata;
                    if (kidx_reg >= KAW'(4) && kidx_reg[1:0] == 2'd0) begin
                        rcon_reg <= aes_pkg::xtime(rcon_reg);
                    end
                    if (kidx_reg == KAW'(KW - 1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        kidx_reg <= kidx_reg + KAW'(1);
                    end
                end
                ST_IDLE: begin
                    if (accept_in) begin
                        dir_run_reg <= dir_reg;
                        cin_reg     <= blk_in;
                        st_reg      <= dir_reg ? blk_in : (blk_in ^ chain_use);
                        chain_reg   <= chain_use;
                        kidx_reg    <= dir_reg ? KAW'(4 * ROUNDS) : KAW'(0);
                        col_reg     <= '0;
                        rnd_reg     <= '0;
                        state_reg   <= ST_PRIME;
                    end
                end
                ST_PRIME: begin
                    // initial key add, one word a cycle; data arrives the cycle after its address
                    if (col_reg != 2'd0 || rnd_reg != '0) begin
                        st_reg[127 - 32*prev_col -: 32] <=
                            st_reg[127 - 32*prev_col -: 32] ^ ram_rdata;
                    end
                    if (rnd_reg != '0) begin
                        rnd_reg   <= RW'(1);
                        col_reg   <= '0;
                        kidx_reg  <= kidx_reg + KAW'(1);
                        state_reg <= ST_RUN;
                    end else begin
                        rnd_reg  <= (col_reg == 2'd3) ? RW'(1) : rnd_reg;
                        col_reg  <= col_reg + 2'd1;
                        kidx_reg <= (dir_run_reg && col_reg == 2'd3) ? kidx_reg - KAW'(7)
                                                                      : kidx_reg + KAW'(1);
                    end
                end
                ST_RUN: begin
                    // kidx_reg was presented last cycle; data is now on ram_rdata
                    nx_reg[127 - 32*col_reg -: 32] <= col_out;
                    kidx_reg <= rd_next;
                    if (col_reg == 2'd3) begin
                        st_reg <= fin;
                        if (last_rnd) begin
                            if (dir_run_reg) begin
                                nx_reg    <= fin ^ chain_reg;
                                chain_reg <= cin_reg;
                            end else begin
                                nx_reg    <= fin;
                                chain_reg <= fin;
                            end
                            state_reg <= ST_DONE;
                        end else begin
                            rnd_reg <= rnd_reg + RW'(1);
                        end
                    end
                    col_reg <= col_reg + 2'd1;
                end
                ST_DONE: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (cfg_key) begin
                // restart expansion from the new key
                state_reg <= ST_EXPAND;
                kidx_reg  <= '0;
                rcon_reg  <= 8'h01;
            end
        end
    end

    assign m_tdata = {nx_reg[63:0], nx_reg[127:64]};

endmodule
